// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent on the same edge
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// geometry, command codes and character codes of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int CMD_W  = 2;

    localparam logic [COL_W:0]    COL_LIMIT  = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W:0]    TAB_C      = (COL_W + 1)'(TAB_STOP);
    localparam logic [ROW_W:0]    ROW_LIMIT  = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W:0]    ROW_LAST   = (ROW_W + 1)'(ROWS - 1);
    localparam logic [ADDR_W-1:0] COLUMNS_A  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

    localparam logic [CHAR_W-1:0] ATTR_RESET  = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

endpackage

// ===== rtl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// text-mode console: cell store, cursor, put / clear / read commands
// ----------------------------------------------------------------------------
// A put that neither scrolls nor wraps past the last row, and any no-op code,
// leaves the sequencer idle, so such items transfer back to back while the
// output does not stall. A read waits in the READ state for the synchronous
// store read. A clear sweeps the store to blanks, and a put that scrolls first
// copies rows up: the single write port of the cell store moves one cell per
// cycle through 1920 cell copies and the 80-cell blank fill. After reset the
// store is swept to blanks (attribute 0x0F), during which no item is accepted;
// attribute writes are taken at any time. One result is returned per item, and
// the next item is accepted while a result waits unless the output is stalled or a read, copy or fill is busy.
module text_console_writer_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tcw_pkg::CHAR_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcw_pkg::CMD_W-1:0]         cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]        cell_address,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcw_pkg::ADDR_W-1:0]        cursor_location,
    output logic [tcw_pkg::CELL_W-1:0]        cell_value
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_COPY = 4'b0100,
        ST_FILL = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [tcw_pkg::ADDR_W-1:0]      ptr_reg, ptr_next;
    logic [tcw_pkg::CELL_W-1:0]      fill_reg, fill_next;
    logic [tcw_pkg::COL_W-1:0]       col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [tcw_pkg::CHAR_W-1:0]      attr_reg;
    logic                            read_ok_reg, read_ok_next;
    logic                            out_valid_reg, out_valid_next;
    logic [tcw_pkg::ADDR_W-1:0]      loc_reg, loc_next;
    logic [tcw_pkg::CELL_W-1:0]      val_reg, val_next;
    logic                            load;

    logic [tcw_pkg::CELL_W-1:0]      mem [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0]      mem_rdata_reg;
    logic                            mem_we, mem_re;
    logic [tcw_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]      mem_wdata;

    logic                            accept;
    logic                            addr_ok;
    logic [tcw_pkg::ADDR_W-1:0]      cur_idx;
    logic [tcw_pkg::CELL_W-1:0]      blank;
    logic [tcw_pkg::COL_W:0]         pc;
    logic [tcw_pkg::ROW_W:0]         pr;
    logic                            put_write;
    logic                            put_scroll;
    logic [tcw_pkg::COL_W-1:0]       put_col;
    logic [tcw_pkg::ROW_W-1:0]       put_row;
    logic [tcw_pkg::ADDR_W-1:0]      put_loc;

    assign in_stall        = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept          = in_valid && !in_stall;
    assign out_valid       = out_valid_reg;
    assign cursor_location = loc_reg;
    assign cell_value      = val_reg;

    assign addr_ok = (cell_address <= tcw_pkg::CELL_LAST);
    assign cur_idx = tcw_pkg::ADDR_W'(row_reg) * tcw_pkg::COLUMNS_A
                   + tcw_pkg::ADDR_W'(col_reg);
    assign blank   = {attr_reg, tcw_pkg::CH_SPACE};

    // cursor update for a put
    always_comb
    begin
        pc        = {1'b0, col_reg};
        pr        = {1'b0, row_reg};
        put_write = 1'b0;
        case (char_code)
            tcw_pkg::CH_BS:
            begin
                if (col_reg != '0)
                begin
                    pc = pc - 1'b1;
                end
            end
            tcw_pkg::CH_TAB:
            begin
                pc = pc + tcw_pkg::TAB_C - (pc % tcw_pkg::TAB_C);
            end
            tcw_pkg::CH_CR:
            begin
                pc = '0;
            end
            tcw_pkg::CH_LF:
            begin
                pc = '0;
                pr = pr + 1'b1;
            end
            default:
            begin
                if (char_code >= tcw_pkg::CH_SPACE && char_code <= tcw_pkg::CH_LAST)
                begin
                    put_write = 1'b1;
                    pc        = pc + 1'b1;
                end
            end
        endcase
        if (pc >= tcw_pkg::COL_LIMIT)
        begin
            pc = '0;
            pr = pr + 1'b1;
        end
        put_scroll = (pr == tcw_pkg::ROW_LIMIT);
        if (put_scroll)
        begin
            pr = tcw_pkg::ROW_LAST;
        end
        put_col = pc[tcw_pkg::COL_W-1:0];
        put_row = pr[tcw_pkg::ROW_W-1:0];
        put_loc = tcw_pkg::ADDR_W'(put_row) * tcw_pkg::COLUMNS_A
                + tcw_pkg::ADDR_W'(put_col);
    end

    // command sequencer
    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        fill_next    = fill_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        read_ok_next = read_ok_reg;
        load         = 1'b0;
        loc_next     = loc_reg;
        val_next     = val_reg;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg;
        mem_wdata    = fill_reg;
        mem_re       = 1'b0;
        mem_raddr    = cell_address;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        tcw_pkg::CMD_PUT:
                        begin
                            col_next  = put_col;
                            row_next  = put_row;
                            mem_we    = put_write;
                            mem_waddr = cur_idx;
                            mem_wdata = {attr_reg, char_code};
                            load      = 1'b1;
                            loc_next  = put_loc;
                            val_next  = '0;
                            if (put_scroll)
                            begin
                                state_next = ST_COPY;
                                ptr_next   = '0;
                                fill_next  = blank;
                            end
                        end
                        tcw_pkg::CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = ST_FILL;
                            ptr_next   = '0;
                            fill_next  = blank;
                            load       = 1'b1;
                            loc_next   = '0;
                            val_next   = '0;
                        end
                        tcw_pkg::CMD_READ:
                        begin
                            mem_re       = addr_ok;
                            read_ok_next = addr_ok;
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                            load     = 1'b1;
                            loc_next = cur_idx;
                            val_next = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                load       = 1'b1;
                loc_next   = cur_idx;
                val_next   = read_ok_reg ? mem_rdata_reg : '0;
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                // read one row down, write the cell read on the previous cycle
                if (ptr_reg != tcw_pkg::COPY_END)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + tcw_pkg::COLUMNS_A;
                end
                if (ptr_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg - 1'b1;
                    mem_wdata = mem_rdata_reg;
                end
                if (ptr_reg == tcw_pkg::COPY_END)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = fill_reg;
                if (ptr_reg == tcw_pkg::CELL_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            ptr_reg       <= '0;
            fill_reg      <= tcw_pkg::BLANK_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            read_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            read_ok_reg   <= read_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            loc_reg <= loc_next;
            val_reg <= val_next;
        end
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

// ===== rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console writer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [tcw_pkg::CMD_W-1:0]      cmd,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [tcw_pkg::ADDR_W-1:0]     cursor_location,
    input logic [tcw_pkg::CELL_W-1:0]     cell_value
);

    // a waiting result blocks the next input transfer
    `ASSERT_SAME(a_stall_blocks_input, clk, rst_n, out_valid && out_stall, in_stall)

    // a clear reports a homed cursor on the next cycle
    `ASSERT_NEXT(a_clear_homes, clk, rst_n, in_valid && !in_stall && cmd == tcw_pkg::CMD_CLEAR, out_valid && cursor_location == '0 && cell_value == '0)

    // cursor stays on the screen
    `ASSERT_SAME(a_cursor_range, clk, rst_n, out_valid, cursor_location <= tcw_pkg::CELL_LAST)

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(cursor_location) && $stable(cell_value))

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);

// ===== tb/sv/text_console_writer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// self-checking bench for the text console: a directed command table, then
// random put / clear / read / no-op traffic in phases with different
// attributes, checked against typed results or a cycle-free console predictor;
// both channels stall at random, with one long output hold-off
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int IDLE_PCT      = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 20000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 24;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor;
        logic [CELL_W-1:0] cell_word;
    } console_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        bit                known;
        console_result_t   result;
    } directed_row_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_write    = 1'b0;
    logic [CHAR_W-1:0] cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  cmd          = CMD_PUT;
    logic [CHAR_W-1:0] char_code    = '0;
    logic [ADDR_W-1:0] cell_address = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [ADDR_W-1:0] cursor_location;
    logic [CELL_W-1:0] cell_value;

    // console predictor state
    logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
    int                shadow_col;
    int                shadow_row;
    logic [CHAR_W-1:0] shadow_attr;

    console_result_t   pending_results [$];
    int                mismatch_count = 0;
    int                quiet_cycles   = 0;
    bit                steady         = 1'b0;
    bit                hold_request   = 1'b0;

    directed_row_t directed_plan [DIRECTED_ROWS] = '{
        '{CMD_READ,  8'h00,    11'd0,     1'b1, '{11'd0,  BLANK_RESET}},
        '{CMD_READ,  8'h00,    CELL_LAST, 1'b1, '{11'd0,  BLANK_RESET}},
        '{CMD_READ,  8'hFF,    11'h7FF,   1'b1, '{11'd0,  16'h0000}},
        '{CMD_NOP,   8'hFF,    11'h7FF,   1'b1, '{11'd0,  16'h0000}},
        '{CMD_PUT,   8'h41,    11'd0,     1'b1, '{11'd1,  16'h0000}},
        '{CMD_PUT,   CH_LAST,  11'h7FF,   1'b1, '{11'd2,  16'h0000}},
        '{CMD_PUT,   CH_SPACE, 11'd0,     1'b1, '{11'd3,  16'h0000}},
        '{CMD_PUT,   CH_BS,    11'd0,     1'b1, '{11'd2,  16'h0000}},
        '{CMD_PUT,   8'hFF,    11'd0,     1'b1, '{11'd2,  16'h0000}},
        '{CMD_PUT,   8'h80,    11'd0,     1'b1, '{11'd2,  16'h0000}},
        '{CMD_PUT,   8'h00,    11'd0,     1'b1, '{11'd2,  16'h0000}},
        '{CMD_PUT,   8'h1F,    11'd0,     1'b1, '{11'd2,  16'h0000}},
        '{CMD_PUT,   CH_TAB,   11'd0,     1'b1, '{11'd8,  16'h0000}},
        '{CMD_PUT,   CH_TAB,   11'd0,     1'b1, '{11'd16, 16'h0000}},
        '{CMD_PUT,   CH_CR,    11'd0,     1'b1, '{11'd0,  16'h0000}},
        '{CMD_PUT,   CH_BS,    11'd0,     1'b1, '{11'd0,  16'h0000}},
        '{CMD_PUT,   CH_LF,    11'd0,     1'b1, '{11'd80, 16'h0000}},
        '{CMD_READ,  8'h00,    11'd0,     1'b1, '{11'd80, 16'h0F41}},
        '{CMD_READ,  8'h00,    11'd1,     1'b1, '{11'd80, 16'h0F7F}},
        '{CMD_PUT,   8'h5A,    11'd0,     1'b0, '{11'd0,  16'h0000}},
        '{CMD_READ,  8'h00,    11'd80,    1'b0, '{11'd0,  16'h0000}},
        '{CMD_CLEAR, 8'h00,    11'd0,     1'b1, '{11'd0,  16'h0000}},
        '{CMD_READ,  8'h00,    11'd1,     1'b1, '{11'd0,  BLANK_RESET}},
        '{CMD_PUT,   8'h7E,    11'd0,     1'b0, '{11'd0,  16'h0000}}
    };

    text_console_writer_unit uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .char_code       (char_code),
        .cell_address    (cell_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_location (cursor_location),
        .cell_value      (cell_value)
    );

    always #CLK_HALF clk = ~clk;

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            shadow_cells[i] = {shadow_attr, CH_SPACE};
        end
    endfunction

    function automatic console_result_t console_predict(input logic [CMD_W-1:0] op,
                                                        input logic [CHAR_W-1:0] ch,
                                                        input logic [ADDR_W-1:0] addr);
        console_result_t r;
        r.cell_word = '0;
        case (op)
            CMD_PUT:
            begin
                if (ch == CH_BS)
                begin
                    if (shadow_col > 0)
                        shadow_col--;
                end
                else if (ch == CH_TAB)
                    shadow_col = shadow_col + TAB_STOP - (shadow_col % TAB_STOP);
                else if (ch == CH_CR)
                    shadow_col = 0;
                else if (ch == CH_LF)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                else if (ch >= CH_SPACE && ch <= CH_LAST)
                begin
                    shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
                    shadow_col++;
                end
                if (shadow_col >= COLUMNS)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // scroll up one row
                if (shadow_row >= ROWS)
                begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                    begin
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                    end
                    for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
                    begin
                        shadow_cells[i] = {shadow_attr, CH_SPACE};
                    end
                    shadow_row = ROWS - 1;
                end
            end
            CMD_CLEAR:
            begin
                blank_screen();
                shadow_col = 0;
                shadow_row = 0;
            end
            CMD_READ:
            begin
                if (addr < CELL_COUNT)
                    r.cell_word = shadow_cells[addr];
            end
            default:
            begin
            end
        endcase
        r.cursor = ADDR_W'(shadow_row * COLUMNS + shadow_col);
        return r;
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [ADDR_W-1:0] addr, input bit known,
                                input console_result_t typed);
        console_result_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        char_code    <= ch;
        cell_address <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = console_predict(op, ch, addr);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic random_command();
        int                pick;
        int                addr_pick;
        logic [CMD_W-1:0]  op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        op   = CMD_PUT;
        ch   = CHAR_W'($urandom);
        addr = ADDR_W'($urandom);
        if (pick < 55)
            ch = CHAR_W'($urandom_range(CH_LAST, CH_SPACE));
        else if (pick < 63)
            ch = CH_LF;
        else if (pick < 67)
            ch = CH_CR;
        else if (pick < 71)
            ch = CH_TAB;
        else if (pick < 75)
            ch = CH_BS;
        else if (pick < 79)
            ch = CHAR_W'($urandom_range(255));
        else if (pick < 81)
            ch = CHAR_W'($urandom_range(255, 128));
        else if (pick < 96)
        begin
            op        = CMD_READ;
            addr_pick = $urandom_range(99);
            // mostly cells on the cursor row, where the writes land
            if (addr_pick < 60)
                addr = ADDR_W'(shadow_row * COLUMNS + $urandom_range(COLUMNS - 1));
            else if (addr_pick < 90)
                addr = ADDR_W'($urandom_range(CELL_COUNT - 1));
            else
                addr = ADDR_W'($urandom_range(2047, CELL_COUNT));
        end
        else if (pick < 98)
            op = CMD_CLEAR;
        else
            op = CMD_NOP;
        send_command(op, ch, addr, 1'b0, '0);
    endtask

    task automatic write_attribute(input logic [CHAR_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write   <= 1'b0;
        shadow_attr = value;
    endtask

    function automatic void check_result();
        console_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected transfer: cursor %0d cell %h",
                         cursor_location, cell_value);
            return;
        end
        want = pending_results.pop_front();
        if (cursor_location !== want.cursor || cell_value !== want.cell_word)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch: cursor exp %0d got %0d, cell exp %h got %h",
                         want.cursor, cursor_location, want.cell_word, cell_value);
        end
    endfunction

    // result side: checking, random stall and one long hold-off
    initial
    begin
        int hold_left = 0;
        bit hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        shadow_attr = ATTR_RESET;
        shadow_col  = 0;
        shadow_row  = 0;
        blank_screen();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            send_command(directed_plan[i].op, directed_plan[i].ch, directed_plan[i].addr,
                         directed_plan[i].known, directed_plan[i].result);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_attribute(phase == 0 ? 8'h00 :
                            phase == 1 ? 8'hFF : CHAR_W'($urandom));
            steady       = (phase == 3);
            hold_request = (phase == 2);
            repeat (PHASE_ITEMS) random_command();
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
